@@ src/cfet_pkg.sv @@
`default_nettype none

package cfet_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int ADDR_W      = 32;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = 7;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REGION_LIMIT = CFG_IDX_W'(1);

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MERGED_BELOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MERGED_ABOVE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MERGED_BOTH  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE      = 3'd5;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    logic [ADDR_W-1:0] block_size;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   resulting_start;
    logic [ADDR_W-1:0]   resulting_size;
    logic [CNT_W-1:0]    entries_in_use;
  } out_t;

  // One table entry as stored in the extent RAM
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } ext_t;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN0,
    OP_ADV,
    OP_HIT,
    OP_WR_LO,
    OP_WR_UP,
    OP_REJ_RANGE,
    OP_REJ_FULL,
    OP_INS,
    OP_SUM,
    OP_WR_BOTH,
    OP_SHUP0,
    OP_SHUP,
    OP_SHDN,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic cnt_dec;
  } dp_cmd_t;

  typedef struct packed {
    logic out_of_range;
    logic cnt_zero;
    logic full;
    logic lt;
    logic scan_last;
    logic at_pos;
    logic pos_at_cnt;
    logic pos_last;
    logic below;
    logic above;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ src/cfet_ram.sv @@
`default_nettype none

module cfet_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/cfet_dp.sv @@
`default_nettype none

module cfet_dp import cfet_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dp_cmd_t              cmd_i,
  output dp_sts_t                   sts_o,
  input  wire in_t                  in_data_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ADDR_W-1:0]    cfg_data_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output out_t                      out_data_o,
  output logic                      ram_we_o,
  output logic [IDX_W-1:0]          ram_waddr_o,
  output ext_t                      ram_wdata_o,
  output logic [IDX_W-1:0]          ram_raddr_o,
  input  wire ext_t                 ram_rdata_i
);

  logic [ADDR_W-1:0]   base_q, limit_q;
  logic [ADDR_W-1:0]   a_q, a_d, z_q, z_d, sum_q, sum_d;
  ext_t                lo_q, lo_d, up_q, up_d;
  logic                lo_vld_q, lo_vld_d, up_vld_q, up_vld_d;
  logic [CNT_W-1:0]    pos_q, pos_d, rd_idx_q, rd_idx_d, count_q, count_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [ADDR_W-1:0]   res_start_q, res_start_d, res_size_q, res_size_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic [CNT_W-1:0]  pos_m1, pos_p1, rd_p1, rd_m1, cnt_m1;
  logic [ADDR_W-1:0] lo_end, a_end, lo_grow, up_grow, both_size;

  assign pos_m1    = pos_q - CNT_W'(1);
  assign pos_p1    = pos_q + CNT_W'(1);
  assign rd_p1     = rd_idx_q + CNT_W'(1);
  assign rd_m1     = rd_idx_q - CNT_W'(1);
  assign cnt_m1    = count_q - CNT_W'(1);
  assign lo_end    = lo_q.start + lo_q.size;
  assign a_end     = a_q + z_q;
  assign lo_grow   = lo_q.size + z_q;
  assign up_grow   = up_q.size + z_q;
  assign both_size = sum_q + up_q.size;

  always_comb begin
    sts_o.out_of_range = (z_q == '0) || (a_q < base_q) || (a_q > limit_q)
                         || (z_q > (limit_q - a_q));
    sts_o.cnt_zero     = (count_q == '0);
    sts_o.full         = (count_q == CNT_W'(MAX_EXTENTS));
    sts_o.lt           = (ram_rdata_i.start < a_q);
    sts_o.scan_last    = (rd_p1 == count_q);
    sts_o.at_pos       = (rd_idx_q == pos_q);
    sts_o.pos_at_cnt   = (pos_q == count_q);
    sts_o.pos_last     = (pos_p1 == count_q);
    sts_o.below        = lo_vld_q && (lo_end == a_q);
    sts_o.above        = up_vld_q && (a_end == up_q.start);
    sts_o.out_busy     = out_valid_q && !out_ready_i;
  end

  always_comb begin
    a_d         = a_q;
    z_d         = z_q;
    sum_d       = sum_q;
    lo_d        = lo_q;
    up_d        = up_q;
    lo_vld_d    = lo_vld_q;
    up_vld_d    = up_vld_q;
    pos_d       = pos_q;
    rd_idx_d    = rd_idx_q;
    count_d     = count_q;
    status_d    = status_q;
    res_start_d = res_start_q;
    res_size_d  = res_size_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;

    case (cmd_i.op)
      OP_LOAD: begin
        a_d = in_data_i.block_address;
        z_d = in_data_i.block_size;
      end
      OP_SCAN0: begin
        rd_idx_d = '0;
        pos_d    = '0;
        lo_vld_d = 1'b0;
        up_vld_d = 1'b0;
      end
      OP_ADV: begin
        lo_d     = ram_rdata_i;
        lo_vld_d = 1'b1;
        pos_d    = rd_p1;
        rd_idx_d = rd_p1;
      end
      OP_HIT: begin
        up_d     = ram_rdata_i;
        up_vld_d = 1'b1;
        pos_d    = rd_idx_q;
      end
      OP_WR_LO: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_m1[IDX_W-1:0];
        ram_wdata_o = '{start: lo_q.start, size: lo_grow};
        status_d    = ST_MERGED_BELOW;
        res_start_d = lo_q.start;
        res_size_d  = lo_grow;
      end
      OP_WR_UP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q[IDX_W-1:0];
        ram_wdata_o = '{start: a_q, size: up_grow};
        status_d    = ST_MERGED_ABOVE;
        res_start_d = a_q;
        res_size_d  = up_grow;
      end
      OP_REJ_RANGE: begin
        status_d    = ST_OUTSIDE;
        res_start_d = '0;
        res_size_d  = '0;
      end
      OP_REJ_FULL: begin
        status_d    = ST_TABLE_FULL;
        res_start_d = '0;
        res_size_d  = '0;
      end
      OP_INS: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q[IDX_W-1:0];
        ram_wdata_o = '{start: a_q, size: z_q};
        count_d     = count_q + CNT_W'(1);
        status_d    = ST_INSERTED;
        res_start_d = a_q;
        res_size_d  = z_q;
      end
      OP_SUM: begin
        sum_d = lo_grow;
      end
      OP_WR_BOTH: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_m1[IDX_W-1:0];
        ram_wdata_o = '{start: lo_q.start, size: both_size};
        status_d    = ST_MERGED_BOTH;
        res_start_d = lo_q.start;
        res_size_d  = both_size;
        rd_idx_d    = pos_p1;
      end
      OP_SHUP0: begin
        rd_idx_d = cnt_m1;
      end
      OP_SHUP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = rd_p1[IDX_W-1:0];
        ram_wdata_o = ram_rdata_i;
        rd_idx_d    = rd_m1;
      end
      OP_SHDN: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = rd_m1[IDX_W-1:0];
        ram_wdata_o = ram_rdata_i;
        rd_idx_d    = rd_p1;
      end
      OP_EMIT: begin
        out_valid_d = 1'b1;
        out_d       = '{status: status_q, resulting_start: res_start_q,
                        resulting_size: res_size_q, entries_in_use: count_q};
      end
      default: begin
      end
    endcase

    if (cmd_i.cnt_dec) begin
      count_d = cnt_m1;
    end
  end

  // Read the entry that the next cycle looks at
  assign ram_raddr_o = rd_idx_d[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      limit_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_REGION_BASE:  base_q  <= cfg_data_i;
          REG_REGION_LIMIT: limit_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    z_q         <= z_d;
    sum_q       <= sum_d;
    lo_q        <= lo_d;
    up_q        <= up_d;
    lo_vld_q    <= lo_vld_d;
    up_vld_q    <= up_vld_d;
    pos_q       <= pos_d;
    rd_idx_q    <= rd_idx_d;
    status_q    <= status_d;
    res_start_q <= res_start_d;
    res_size_q  <= res_size_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_EXTENTS))
    else $error("extent count above table depth");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_EMIT |-> !(out_valid_q && !out_ready_i))
    else $error("result overwrites a pending word");

  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_INS |-> count_q < CNT_W'(MAX_EXTENTS))
    else $error("insert into a full table");

  a_lo_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_WR_LO || cmd_i.op == OP_WR_BOTH) |-> lo_vld_q && pos_q != '0)
    else $error("lower merge without lower neighbor");

  a_up_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_WR_UP || cmd_i.op == OP_WR_BOTH) |-> up_vld_q && pos_q < count_q)
    else $error("upper merge without upper neighbor");

endmodule

`default_nettype wire

@@ src/cfet_ctrl.sv @@
`default_nettype none

module cfet_ctrl import cfet_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_MERGE  = 4'd4;
  localparam logic [3:0] S_SHDN   = 4'd5;
  localparam logic [3:0] S_SHUP   = 4'd6;
  localparam logic [3:0] S_INS    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = OP_NONE;
    cmd_o.cnt_dec = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.out_of_range) begin
          cmd_o.op = OP_REJ_RANGE;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_SCAN0;
          state_d  = sts_i.cnt_zero ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.lt) begin
          cmd_o.op = OP_ADV;
          if (sts_i.scan_last) begin
            state_d = S_DECIDE;
          end
        end else begin
          cmd_o.op = OP_HIT;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.below && sts_i.above) begin
          cmd_o.op = OP_SUM;
          state_d  = S_MERGE;
        end else if (sts_i.below) begin
          cmd_o.op = OP_WR_LO;
          state_d  = S_DONE;
        end else if (sts_i.above) begin
          cmd_o.op = OP_WR_UP;
          state_d  = S_DONE;
        end else if (sts_i.full) begin
          cmd_o.op = OP_REJ_FULL;
          state_d  = S_DONE;
        end else if (sts_i.pos_at_cnt) begin
          cmd_o.op = OP_INS;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_SHUP0;
          state_d  = S_SHUP;
        end
      end
      S_MERGE: begin
        cmd_o.op = OP_WR_BOTH;
        if (sts_i.pos_last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end else begin
          state_d = S_SHDN;
        end
      end
      S_SHDN: begin
        cmd_o.op = OP_SHDN;
        if (sts_i.scan_last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_SHUP: begin
        cmd_o.op = OP_SHUP;
        if (sts_i.at_pos) begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        cmd_o.op = OP_INS;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_shift_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHUP || state_q == S_SHDN) |-> !sts_i.cnt_zero)
    else $error("shifting an empty table");

  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !sts_i.out_busy) |=> in_ready_o)
    else $error("result emitted without return to idle");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_CHECK)
    else $error("accepted word not checked");

endmodule

`default_nettype wire

@@ src/coalescing_free_extent_table.sv @@
// Channel  Handshake                Payload                  Dir
// -------  -----------------------  -----------------------  ---
// in       in_valid_i / in_ready_o  in_data_i  (in_t)        in
// out      out_valid_o / out_ready_i out_data_o (out_t)      out
// cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i in
//
// One word at a time: the single read and write port of the extent RAM sets
// the pace (one entry scanned or shifted per cycle), and a held result adds
// its stall.
// Reset clears the region registers and the extent count; entries at or
// above the count are never used, so no clearing pass is run.
// One result register decouples the output: the next word is accepted while
// a result waits, and its own result holds until that register drains.
// Config writes are always taken.
`default_nettype none

module coalescing_free_extent_table import cfet_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_t                      out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ADDR_W-1:0]    cfg_data_i
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  ext_t             ram_wdata, ram_rdata;
  logic [$bits(ext_t)-1:0] ram_rword;

  // Region registers accept a word every cycle
  assign cfg_ready_o = 1'b1;

  // Sequence scan, merge and shift steps
  cfet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the word under work, the neighbors, the count and the result
  cfet_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Sorted extent table: start and size per entry
  cfet_ram #(
    .WIDTH ($bits(ext_t)),
    .DEPTH (MAX_EXTENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rword)
  );

  assign ram_rdata = ext_t'(ram_rword);

endmodule

`default_nettype wire

@@ dv/tb.sv @@
module tb;
  import cfet_pkg::*;

  // Spare register index: writes to it must leave the region untouched.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(9);

  // Random release words per phase (eight phases, about 1950 words in all).
  localparam int PHASE_WORDS = 240;
  // Receiver hold-off, long enough to back the block up into its input.
  localparam int HOLD_CYCLES = 400;
  // Cycles without any handshake before the run is declared hung. The
  // longest quiet stretch of a correct run is the hold-off above, or the
  // processing of one word stretched by random stalls.
  localparam int QUIET_LIMIT = 4000;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data  = '0;

  // Release words waiting for the driver, and outcomes waiting for the block.
  in_t  release_q[$];
  out_t pending_outcomes[$];

  int n_queued   = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_fail     = 0;

  // Idling knobs, percent of cycles; set per phase by the stimulus.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Hold-off requests: stimulus bumps hold_asks, the receiver counts it out.
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int quiet_cycles = 0;

  // Shadow of the free-extent table and the region registers.
  logic [ADDR_W-1:0] free_start [MAX_EXTENTS];
  logic [ADDR_W-1:0] free_size  [MAX_EXTENTS];
  int                free_count = 0;
  logic [ADDR_W-1:0] free_base  = '0;
  logic [ADDR_W-1:0] free_limit = '0;

  coalescing_free_extent_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Release one extent into the shadow table and return the outcome word.
  // All sums and adjacency tests wrap at the address width, so overlapping
  // releases follow the same arithmetic as the hardware.
  function automatic out_t release_extent(in_t w);
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] z;
    int                pos;
    logic              touch_lo;
    logic              touch_hi;
    out_t              r;
    a        = w.block_address;
    z        = w.block_size;
    r        = '0;
    pos      = 0;
    touch_lo = 1'b0;
    touch_hi = 1'b0;
    // Reject empty extents and anything not fully inside [base, limit].
    if (z == '0 || a < free_base || a > free_limit || z > free_limit - a) begin
      r.status         = ST_OUTSIDE;
      r.entries_in_use = CNT_W'(free_count);
      return r;
    end
    // Locate the first entry at or above the release; the one before it is
    // the lower neighbor.
    while (pos < free_count && free_start[pos] < a) pos++;
    if (pos > 0) touch_lo = (free_start[pos-1] + free_size[pos-1]) == a;
    if (pos < free_count) touch_hi = (a + z) == free_start[pos];
    if (touch_lo && touch_hi) begin
      // Join both neighbors and close the hole left by the upper one.
      free_size[pos-1] = free_size[pos-1] + z + free_size[pos];
      for (int i = pos; i + 1 < free_count; i++) begin
        free_start[i] = free_start[i+1];
        free_size[i]  = free_size[i+1];
      end
      free_count--;
      r.status          = ST_MERGED_BOTH;
      r.resulting_start = free_start[pos-1];
      r.resulting_size  = free_size[pos-1];
    end else if (touch_lo) begin
      free_size[pos-1]  = free_size[pos-1] + z;
      r.status          = ST_MERGED_BELOW;
      r.resulting_start = free_start[pos-1];
      r.resulting_size  = free_size[pos-1];
    end else if (touch_hi) begin
      free_start[pos]   = a;
      free_size[pos]    = free_size[pos] + z;
      r.status          = ST_MERGED_ABOVE;
      r.resulting_start = free_start[pos];
      r.resulting_size  = free_size[pos];
    end else if (free_count >= MAX_EXTENTS) begin
      r.status = ST_TABLE_FULL;
    end else begin
      // Open a slot at pos and insert in address order.
      for (int i = free_count; i > pos; i--) begin
        free_start[i] = free_start[i-1];
        free_size[i]  = free_size[i-1];
      end
      free_start[pos]   = a;
      free_size[pos]    = z;
      free_count++;
      r.status          = ST_INSERTED;
      r.resulting_start = a;
      r.resulting_size  = z;
    end
    r.entries_in_use = CNT_W'(free_count);
    return r;
  endfunction

  // Sender: predict on acceptance, then offer the next word or idle.
  // Valid only drops after a handshake, so a held word never changes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        pending_outcomes.push_back(release_extent(in_data));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (release_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= release_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each result word with the oldest outcome, then pick
  // ready for the next cycle. A pending hold-off request wins over random
  // stalls and keeps ready low until its hold-off count runs out.
  always @(posedge clk_i or negedge rst_ni) begin : take_results
    out_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("result word with no outcome pending: status %0d start %h size %h",
                 out_data.status, out_data.resulting_start, out_data.resulting_size);
          n_fail++;
        end else begin
          want = pending_outcomes.pop_front();
          n_checked++;
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            n_fail++;
          end
          if (out_data.resulting_start !== want.resulting_start) begin
            $error("resulting_start: expected %h, got %h",
                   want.resulting_start, out_data.resulting_start);
            n_fail++;
          end
          if (out_data.resulting_size !== want.resulting_size) begin
            $error("resulting_size: expected %h, got %h",
                   want.resulting_size, out_data.resulting_size);
            n_fail++;
          end
          if (out_data.entries_in_use !== want.entries_in_use) begin
            $error("entries_in_use: expected %0d, got %0d",
                   want.entries_in_use, out_data.entries_in_use);
            n_fail++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: end the run if no channel moves a word for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic offer(input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] len);
    in_t w;
    w.block_address = addr;
    w.block_size    = len;
    release_q.push_back(w);
    n_queued++;
  endtask

  // Write one register; update the shadow copy once the write is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == REG_REGION_BASE) free_base = val;
    else if (idx == REG_REGION_LIMIT) free_limit = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_region(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
    write_reg(REG_REGION_BASE, lo);
    write_reg(REG_REGION_LIMIT, hi);
  endtask

  // Hold until every queued word is accepted and its result has come back.
  task automatic wait_idle();
    while (n_accepted != n_queued || n_checked != n_accepted) @(posedge clk_i);
  endtask

  // Release every gap between disjoint neighbors of the current table, so
  // the leftovers of earlier phases collapse into few entries. Call only
  // while idle, with the whole address space as the region.
  task automatic sweep_gaps();
    logic [ADDR_W:0] tail;
    for (int i = 0; i + 1 < free_count; i++) begin
      tail = {1'b0, free_start[i]} + {1'b0, free_size[i]};
      if (!tail[ADDR_W] && tail[ADDR_W-1:0] < free_start[i+1])
        offer(tail[ADDR_W-1:0], free_start[i+1] - tail[ADDR_W-1:0]);
    end
  endtask

  // Odd releases that break or probe the region rules, or overlap freed space.
  task automatic noise(input logic [ADDR_W-1:0] near);
    int          pick;
    int unsigned k;
    pick = $urandom_range(7);
    k    = $urandom_range(15);
    if (pick < 4) begin
      offer($urandom, $urandom >> $urandom_range(31));
    end else if (pick == 4) begin
      offer(near + $urandom_range(255), $urandom_range(64, 1));
    end else if (pick == 5) begin
      offer(near, '0);
    end else if (pick == 6) begin
      offer(free_limit - k, k + 1);
    end else begin
      offer(free_base - 1, $urandom_range(64, 1));
    end
  endtask

  // Fill the table from a known count: free every other granule until one
  // release past the last slot is refused, offer it once more, then free the
  // gaps (each but the last joins two neighbors) and finally the refused granule.
  task automatic fill_to_full(inout logic [ADDR_W-1:0] cursor);
    int room;
    int g;
    room = MAX_EXTENTS - free_count;
    g    = $urandom_range(256, 1);
    for (int j = 0; j <= room; j++) offer(cursor + ADDR_W'(2 * j * g), g);
    offer(cursor + ADDR_W'(2 * room * g), g);
    for (int j = 0; j < room; j++) offer(cursor + ADDR_W'((2 * j + 1) * g), g);
    offer(cursor + ADDR_W'(2 * room * g), g);
    cursor = cursor + ADDR_W'((2 * room + 1) * g);
  endtask

  // Free a window of granules in random runs until all of it is free; the
  // window ends as one extent, with inserts and merges on the way.
  task automatic shuffle_window(inout logic [ADDR_W-1:0] cursor);
    logic freed [24];
    int   n;
    int   g;
    int   s;
    int   len;
    int   want;
    int   left;
    n    = $urandom_range(24, 2);
    g    = $urandom_range(4096, 1);
    left = n;
    foreach (freed[k]) freed[k] = 1'b0;
    while (left > 0) begin
      s = $urandom_range(n - 1);
      while (freed[s]) s = (s + 1) % n;
      want = $urandom_range(3, 1);
      len  = 1;
      while (len < want && s + len < n && !freed[s+len]) len++;
      for (int k = s; k < s + len; k++) freed[k] = 1'b1;
      left -= len;
      offer(cursor + ADDR_W'(s * g), ADDR_W'(len * g));
      if ($urandom_range(99) < 8) noise(cursor);
    end
    cursor = cursor + ADDR_W'(n * g);
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] cursor;
    int                mark;
    int                mode;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Region registers at reset: base and limit both zero, nothing fits.
    offer(32'h0000_0000, 32'h0000_0000);
    offer(32'h0000_0000, 32'h0000_0001);
    wait_idle();

    set_region(32'h0000_0100, 32'h0000_1000);
    offer(32'h0000_00FF, 32'h0000_0001);  // below base
    offer(32'h0000_0100, 32'h0000_0000);  // zero size
    offer(32'h0000_0100, 32'h0000_0010);  // insert at base
    offer(32'h0000_0110, 32'h0000_0010);  // merge below
    offer(32'h0000_0130, 32'h0000_0010);  // insert
    offer(32'h0000_0120, 32'h0000_0010);  // merge both
    offer(32'h0000_0200, 32'h0000_0010);  // insert
    offer(32'h0000_01F0, 32'h0000_0010);  // merge above
    offer(32'h0000_0FF0, 32'h0000_0010);  // ends exactly at limit
    offer(32'h0000_0FF0, 32'h0000_0011);  // one past limit
    offer(32'h0000_1000, 32'h0000_0001);  // starts at limit
    offer(32'h0000_0200, 32'hFFFF_FFFF);  // end wraps around
    offer(32'h0000_0108, 32'h0000_0008);  // overlaps a free extent
    wait_idle();

    // Base above limit: every release is refused.
    set_region(32'hFFFF_FFFF, 32'h0000_0000);
    offer(32'hFFFF_FFFF, 32'h0000_0000);
    offer(32'h8000_0000, 32'h0000_0001);
    wait_idle();

    // Whole address space; the spare index must not disturb the region.
    set_region(32'h0000_0000, 32'hFFFF_FFFF);
    write_reg(REG_SPARE, 32'h5A5A_5A5A);
    offer(32'hFFFF_FFFE, 32'h0000_0001);
    offer(32'h0000_0000, 32'hFFFF_FFFF);
    offer(32'hFFFF_FFFF, 32'h0000_0000);
    offer(32'hFFFF_FFFF, 32'h0000_0001);

    for (int p = 0; p < 8; p++) begin
      // Pause the sender here until every outcome is back.
      wait_idle();
      send_idle_pct = 0;
      stall_pct     = 0;
      set_region(32'h0000_0000, 32'hFFFF_FFFF);
      sweep_gaps();
      wait_idle();

      span = ADDR_W'(1) << $urandom_range(28, 24);
      if (p == 3) lo = '0;
      else if (p == 7) lo = 32'hFFFF_FFFF - span;
      else lo = $urandom_range(32'hFFFF_FFFF - span);
      set_region(lo, lo + span);

      // Idling mode: none, sender only, receiver only, both.
      mode          = p % 4;
      send_idle_pct = (mode == 1) ? 52 : (mode == 3) ? 36 : 0;
      stall_pct     = (mode == 2) ? 52 : (mode == 3) ? 36 : 0;
      // Back the block up behind a held-off receiver while words keep coming.
      if (mode == 0) hold_asks++;

      mark   = n_queued;
      cursor = free_base;
      if (p % 3 == 0) fill_to_full(cursor);
      while (n_queued - mark < PHASE_WORDS && free_limit - cursor > 32'h0002_0000) begin
        // Leave a gap now and then so a new window starts its own extent.
        if ($urandom_range(2) == 0) cursor = cursor + $urandom_range(4096, 1);
        shuffle_window(cursor);
      end
    end

    wait_idle();
    // Drain: give a stray extra result time to show up.
    repeat (MAX_EXTENTS + 16) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/cfet_pkg.sv
src/cfet_ram.sv
src/cfet_dp.sv
src/cfet_ctrl.sv
src/coalescing_free_extent_table.sv
dv/tb.sv
